// ----- src/teqd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teqd_pkg
// Shared constants and types for the timestamped event quantum dispatcher.
// ----------------------------------------------------------------------------
package teqd_pkg;

  // Sizing
  localparam int QUANTUM_FRAMES         = 128;  // 1 .. 1024
  localparam int MAX_EVENTS_PER_QUANTUM = 16;   // 1 .. 64
  localparam int RING_DEPTH             = 64;   // 2 .. 1024

  // Derived widths
  localparam int RING_AW = $clog2(RING_DEPTH);       // ring index
  localparam int RING_CW = $clog2(RING_DEPTH + 1);   // ring occupancy
  localparam int RING_SW = RING_AW + 1;              // index + count before wrap
  localparam int QPOS_W  = $clog2(QUANTUM_FRAMES + 1);
  localparam int TIME_W  = 48;
  localparam int OFFS_W  = 10;

  // Cap on emitted events, never more than the ring can hold
  localparam int EMIT_CAP = (MAX_EVENTS_PER_QUANTUM < RING_DEPTH) ?
                            MAX_EVENTS_PER_QUANTUM : RING_DEPTH;

  // Operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [31:0]       sequence_no;
    logic [7:0]        action;
    logic [31:0]       value;
  } ring_entry_t;

endpackage

// ----- src/timestamped_event_quantum_dispatch_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_event_quantum_dispatch_unit
// Stamps host callback events into a ring and drains them at quantum starts.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+--------------------------------------
//  request   | start / busy             | operation, frame_count,
//            | (taken: start && !busy)  | outputs_present, event_offset,
//            |                          | event_sequence, event_action,
//            |                          | event_value
//  result    | strobe (one cycle each)  | kind, quantum_offset, out_sequence,
//            |                          | out_action, out_value, read_position,
//            |                          | dropped_total, last
//
//  Begin, event and ignored requests complete when taken; a plain frame request
//  completes when taken and its result shows in the following cycle.
//  A frame request that opens a quantum with p of c pending events due and
//  e = min(p, cap) emitted holds busy through its quantum start result, its e
//  event results and its read position result; its last result shows in the
//  cycle busy falls. The ring memory is walked twice, once to count due events
//  (so every result carries the final drop count) and once to emit them, each registered read in a state of its own.
//  rst is synchronous, active high; it clears all control state. Ring
//  contents are not cleared, entries are read only after being written.
//  Results cannot be stalled by the receiver; busy holds off new requests.
//
module timestamped_event_quantum_dispatch_unit (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] frame_count,
  input  logic        outputs_present,
  input  logic [15:0] event_offset,
  input  logic [31:0] event_sequence,
  input  logic [7:0]  event_action,
  input  logic [31:0] event_value,
  // result
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [9:0]  quantum_offset,
  output logic [31:0] out_sequence,
  output logic [7:0]  out_action,
  output logic [31:0] out_value,
  output logic [9:0]  read_position,
  output logic [31:0] dropped_total,
  output logic        last
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_RD = 3'd1;  // read ring entry for due check
  localparam logic [2:0] S_SCAN_EV = 3'd2;  // compare stamp with quantum end
  localparam logic [2:0] S_START   = 3'd3;  // quantum start result
  localparam logic [2:0] S_EMIT_RD = 3'd4;  // read ring entry for dispatch
  localparam logic [2:0] S_EMIT    = 3'd5;  // dispatched event result
  localparam logic [2:0] S_FRAME   = 3'd6;  // read position result, commit

  localparam int AW = teqd_pkg::RING_AW;
  localparam int CW = teqd_pkg::RING_CW;
  localparam int SW = teqd_pkg::RING_SW;
  localparam int QW = teqd_pkg::QPOS_W;
  localparam int TW = teqd_pkg::TIME_W;
  localparam int OW = teqd_pkg::OFFS_W;

  localparam logic [SW-1:0] DEPTH_S  = SW'(teqd_pkg::RING_DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(teqd_pkg::RING_DEPTH);
  localparam logic [CW-1:0] CAP_C    = CW'(teqd_pkg::EMIT_CAP);
  localparam logic [QW-1:0] QF_Q     = QW'(teqd_pkg::QUANTUM_FRAMES);
  localparam logic [TW-1:0] QF_T     = TW'(teqd_pkg::QUANTUM_FRAMES);
  localparam logic [AW-1:0] LAST_IDX = AW'(teqd_pkg::RING_DEPTH - 1);

  // Ring memory: one word per event, registered read
  teqd_pkg::ring_entry_t ring_mem [teqd_pkg::RING_DEPTH];
  teqd_pkg::ring_entry_t rd_entry;
  teqd_pkg::ring_entry_t wr_entry;

  logic [2:0]    state;
  logic [AW-1:0] ring_head;
  logic [CW-1:0] ring_count;
  logic [TW-1:0] callback_origin;
  logic [15:0]   callback_frames;
  logic [15:0]   frames_taken;
  logic          callback_valid;
  logic [TW-1:0] generated_frames;
  logic [QW-1:0] quantum_position;
  logic [31:0]   drop_counter;

  // Drain working registers
  logic [TW-1:0] drain_end;
  logic [AW-1:0] ptr;         // walking ring index
  logic [CW-1:0] due_count;   // events popped this quantum
  logic [CW-1:0] emit_count;  // events to dispatch
  logic [CW-1:0] emit_done;
  logic [31:0]   drop_final;  // drop counter after this request

  logic          accept;
  logic          wr_en;
  logic [SW-1:0] wr_sum;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] head_sum;
  logic [AW-1:0] head_next;
  logic [AW-1:0] ptr_next;
  logic          frame_ok;
  logic          new_quantum;
  logic [CW-1:0] emit_next;
  logic [32:0]   drop_sum;
  logic [31:0]   drop_final_next;
  logic [31:0]   drop_inc;
  logic [TW-1:0] offs_full;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Ring write index: head + count, wrapped once
  assign wr_sum  = SW'(ring_head) + SW'(ring_count);
  assign wr_addr = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : AW'(wr_sum);
  assign wr_en   = accept && (operation == teqd_pkg::OP_EVENT) &&
                   callback_valid && (ring_count < DEPTH_C);

  assign wr_entry.stamp       = callback_origin + TW'(event_offset);
  assign wr_entry.sequence_no = event_sequence;
  assign wr_entry.action      = event_action;
  assign wr_entry.value       = event_value;

  // Head after popping every due event
  assign head_sum  = SW'(ring_head) + SW'(due_count);
  assign head_next = (head_sum >= DEPTH_S) ? AW'(head_sum - DEPTH_S) : AW'(head_sum);
  assign ptr_next  = (ptr == LAST_IDX) ? '0 : ptr + AW'(1);

  assign frame_ok    = callback_valid && (frames_taken < callback_frames);
  assign new_quantum = (quantum_position >= QF_Q);

  // Events beyond the cap are dropped; fold them into the counter up front
  assign emit_next       = (due_count > CAP_C) ? CAP_C : due_count;
  assign drop_sum        = {1'b0, drop_counter} + 33'(due_count - emit_next);
  assign drop_final_next = drop_sum[32] ? '1 : drop_sum[31:0];
  assign drop_inc        = (drop_counter == '1) ? drop_counter : drop_counter + 32'd1;

  // Offset from quantum start, zero when late
  assign offs_full = (rd_entry.stamp <= generated_frames) ? '0 :
                     rd_entry.stamp - generated_frames;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_entry;
    end
    rd_entry <= ring_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ring_head        <= '0;
      ring_count       <= '0;
      callback_origin  <= '0;
      callback_frames  <= '0;
      frames_taken     <= '0;
      callback_valid   <= 1'b0;
      generated_frames <= '0;
      quantum_position <= QF_Q;
      drop_counter     <= '0;
      strobe           <= 1'b0;
      ptr              <= '0;
      due_count        <= '0;
      emit_count       <= '0;
      emit_done        <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (operation)
              teqd_pkg::OP_BEGIN: begin
                if (callback_valid) begin
                  callback_origin <= callback_origin + TW'(callback_frames);
                end
                callback_frames <= frame_count;
                frames_taken    <= '0;
                callback_valid  <= (frame_count != '0) && outputs_present;
              end
              teqd_pkg::OP_EVENT: begin
                if (wr_en) begin
                  ring_count <= ring_count + CW'(1);
                end else begin
                  drop_counter <= drop_inc;
                end
              end
              teqd_pkg::OP_FRAME: begin
                if (frame_ok) begin
                  frames_taken <= frames_taken + 16'd1;
                  if (new_quantum) begin
                    drain_end <= generated_frames + QF_T;
                    ptr       <= ring_head;
                    due_count <= '0;
                    state     <= S_SCAN_RD;
                  end else begin
                    // Plain frame: single read position result
                    strobe           <= 1'b1;
                    kind             <= teqd_pkg::KIND_FRAME;
                    quantum_offset   <= '0;
                    out_sequence     <= '0;
                    out_action       <= '0;
                    out_value        <= '0;
                    read_position    <= OW'(quantum_position);
                    dropped_total    <= drop_counter;
                    last             <= 1'b1;
                    quantum_position <= quantum_position + QW'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= (due_count == ring_count) ? S_START : S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (rd_entry.stamp < drain_end) begin
            due_count <= due_count + CW'(1);
            ptr       <= ptr_next;
            state     <= S_SCAN_RD;
          end else begin
            state <= S_START;
          end
        end
        S_START: begin
          emit_count     <= emit_next;
          drop_final     <= drop_final_next;
          emit_done      <= '0;
          ptr            <= ring_head;
          strobe         <= 1'b1;
          kind           <= teqd_pkg::KIND_START;
          quantum_offset <= '0;
          out_sequence   <= '0;
          out_action     <= '0;
          out_value      <= '0;
          read_position  <= '0;
          dropped_total  <= drop_final_next;
          last           <= 1'b0;
          state          <= S_EMIT_RD;
        end
        S_EMIT_RD: begin
          state <= (emit_done == emit_count) ? S_FRAME : S_EMIT;
        end
        S_EMIT: begin
          strobe         <= 1'b1;
          kind           <= teqd_pkg::KIND_EVENT;
          quantum_offset <= OW'(offs_full);
          out_sequence   <= rd_entry.sequence_no;
          out_action     <= rd_entry.action;
          out_value      <= rd_entry.value;
          read_position  <= '0;
          dropped_total  <= drop_final;
          last           <= 1'b0;
          emit_done      <= emit_done + CW'(1);
          ptr            <= ptr_next;
          state          <= S_EMIT_RD;
        end
        S_FRAME: begin
          // Commit the pops and the new quantum, report position zero
          ring_head        <= head_next;
          ring_count       <= ring_count - due_count;
          generated_frames <= drain_end;
          drop_counter     <= drop_final;
          quantum_position <= QW'(1);
          strobe           <= 1'b1;
          kind             <= teqd_pkg::KIND_FRAME;
          quantum_offset   <= '0;
          out_sequence     <= '0;
          out_action       <= '0;
          out_value        <= '0;
          read_position    <= '0;
          dropped_total    <= drop_final;
          last             <= 1'b1;
          state            <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/teqd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teqd_checker
// Port-level checks for the timestamped event quantum dispatcher.
// ----------------------------------------------------------------------------
module teqd_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       strobe,
  input logic [1:0] kind,
  input logic       last
);

  // Begin, event and ignored requests give no result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation != teqd_pkg::OP_FRAME) |=> !strobe)
    else $error("result after a request that gives none");

  // The read position result always closes a request, and only it does
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((kind == teqd_pkg::KIND_FRAME) == last))
    else $error("last flag does not match frame result");

  // More results pending keeps new requests out
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("idle while a drain is still emitting");

  // A quantum start is followed by more results of the same request
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == teqd_pkg::KIND_START) |=> busy)
    else $error("drain ended right after quantum start");

endmodule

bind timestamped_event_quantum_dispatch_unit teqd_checker u_teqd_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .strobe    (strobe),
  .kind      (kind),
  .last      (last)
);
